FILE: hdl/mmbd_pkg.sv
// shared constants and types for the min/max bucket downsampler
`default_nettype none
package mmbd_pkg;

  localparam int VALUE_BITS_DEF    = 32;
  localparam int POSITION_BITS_DEF = 24;
  localparam int TAG_BITS          = 32;
  localparam int COUNT_BITS        = 24;
  localparam int BUCKET_BITS       = 16;
  localparam int CFG_INDEX_BITS    = 1;
  localparam int CFG_DATA_BITS     = 24;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SAMPLE_COUNT = 1'b0,
    REG_BUCKET_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic two;
    logic fend;
  } pair_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/mmbd_ifs.sv
// sample and point stream interfaces
`default_nettype none
interface mmbd_sample_if #(
  parameter int VALUE_BITS = mmbd_pkg::VALUE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [VALUE_BITS-1:0]   sample_value;
  logic [mmbd_pkg::TAG_BITS-1:0]  sample_tag;

  modport source (output valid, output sample_value, output sample_tag, input ready);
  modport sink (input valid, input sample_value, input sample_tag, output ready);
endinterface

interface mmbd_point_if #(
  parameter int VALUE_BITS    = mmbd_pkg::VALUE_BITS_DEF,
  parameter int POSITION_BITS = mmbd_pkg::POSITION_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [VALUE_BITS-1:0]   point_value;
  logic [mmbd_pkg::TAG_BITS-1:0]  point_tag;
  logic [POSITION_BITS-1:0]       point_index;
  logic                           run_last;
  logic                           frame_end;

  modport source (
    output valid, output point_value, output point_tag, output point_index,
    output run_last, output frame_end, input ready
  );
  modport sink (
    input valid, input point_value, input point_tag, input point_index,
    input run_last, input frame_end, output ready
  );
endinterface
`default_nettype wire

FILE: hdl/mmbd_core.sv
// input register, bucket tracking and min/max selection
`default_nettype none
module mmbd_core #(
  parameter int VALUE_BITS    = mmbd_pkg::VALUE_BITS_DEF,
  parameter int POSITION_BITS = mmbd_pkg::POSITION_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [VALUE_BITS-1:0]        in_value,
  input  wire logic [mmbd_pkg::TAG_BITS-1:0]       in_tag,
  input  wire logic [mmbd_pkg::COUNT_BITS-1:0]     sample_count,
  input  wire logic [mmbd_pkg::BUCKET_BITS-1:0]    num_buckets,
  input  wire logic                                pair_ready,
  output mmbd_pkg::pair_ctl_t                      ctl,
  output logic signed [VALUE_BITS-1:0]             p0_value,
  output logic [mmbd_pkg::TAG_BITS-1:0]            p0_tag,
  output logic [POSITION_BITS-1:0]                 p0_index,
  output logic signed [VALUE_BITS-1:0]             p1_value,
  output logic [mmbd_pkg::TAG_BITS-1:0]            p1_tag,
  output logic [POSITION_BITS-1:0]                 p1_index
);

  localparam int AW = POSITION_BITS + 1;
  localparam int WW = ((AW > mmbd_pkg::COUNT_BITS) ? AW : mmbd_pkg::COUNT_BITS) + 1;

  // input register
  logic                          hold_valid;
  logic signed [VALUE_BITS-1:0]  hold_value;
  logic [mmbd_pkg::TAG_BITS-1:0] hold_tag;

  // frame and bucket state
  logic [POSITION_BITS-1:0]      sample_position;
  logic [AW-1:0]                 boundary_accumulator;
  logic                          bucket_open;
  logic signed [VALUE_BITS-1:0]  low_value, high_value;
  logic [mmbd_pkg::TAG_BITS-1:0] low_tag, high_tag;
  logic [POSITION_BITS-1:0]      low_position, high_position;

  logic                          fire;
  logic                          zero_count, pass_through, fend, first, close;
  logic                          low_take, high_take, flat;
  logic [WW-1:0]                 n_w, b_w, pos_inc, acc_in, acc_sum;
  logic [POSITION_BITS-1:0]      pos_eff, position_next;
  logic [AW-1:0]                 accumulator_next;
  logic signed [VALUE_BITS-1:0]  lv, hv;
  logic [mmbd_pkg::TAG_BITS-1:0] lt, ht;
  logic [POSITION_BITS-1:0]      lp, hp;

  assign fire     = hold_valid && pair_ready;
  assign in_ready = !hold_valid || pair_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_value <= in_value;
      hold_tag   <= in_tag;
    end
  end

  always_comb begin
    n_w          = WW'(sample_count);
    b_w          = WW'(num_buckets);
    zero_count   = (sample_count == '0) || (num_buckets == '0);
    pass_through = n_w <= b_w;
    pos_eff      = (WW'(sample_position) >= n_w) ? '0 : sample_position;
    pos_inc      = WW'(pos_eff) + WW'(1);
    fend         = pos_inc == n_w;
    position_next = fend ? '0 : pos_inc[POSITION_BITS-1:0];
    acc_in       = (pos_eff == '0) ? (n_w - b_w) : WW'(boundary_accumulator);
    first        = (pos_eff == '0) || !bucket_open;
    low_take     = first || (hold_value < low_value);
    high_take    = first || (hold_value > high_value);
    lv           = low_take  ? hold_value : low_value;
    lt           = low_take  ? hold_tag   : low_tag;
    lp           = low_take  ? pos_eff    : low_position;
    hv           = high_take ? hold_value : high_value;
    ht           = high_take ? hold_tag   : high_tag;
    hp           = high_take ? pos_eff    : high_position;
    close        = (acc_in < b_w) || fend;
    acc_sum      = close ? (acc_in + n_w - b_w) : (acc_in - b_w);
    accumulator_next = acc_sum[AW-1:0];
    flat         = lv == hv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position      <= '0;
      boundary_accumulator <= '0;
      bucket_open          <= 1'b0;
    end else if (fire) begin
      if (zero_count) begin
        sample_position      <= '0;
        boundary_accumulator <= '0;
        bucket_open          <= 1'b0;
      end else if (pass_through) begin
        sample_position      <= position_next;
        boundary_accumulator <= '0;
        bucket_open          <= 1'b0;
      end else begin
        sample_position      <= position_next;
        boundary_accumulator <= accumulator_next;
        bucket_open          <= !close;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !zero_count && !pass_through) begin
      low_value     <= lv;
      low_tag       <= lt;
      low_position  <= lp;
      high_value    <= hv;
      high_tag      <= ht;
      high_position <= hp;
    end
  end

  always_comb begin
    ctl.load = fire && !zero_count && (pass_through || close);
    ctl.two  = !pass_through && !flat;
    ctl.fend = fend;
    p1_value = hv;
    p1_tag   = ht;
    p1_index = hp;
    if (pass_through) begin
      p0_value = hold_value;
      p0_tag   = hold_tag;
      p0_index = pos_eff;
    end else if (flat || lp <= hp) begin
      p0_value = lv;
      p0_tag   = lt;
      p0_index = lp;
    end else begin
      p0_value = hv;
      p0_tag   = ht;
      p0_index = hp;
      p1_value = lv;
      p1_tag   = lt;
      p1_index = lp;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mmbd_out.sv
// two-slot result register that sends one point per request
`default_nettype none
module mmbd_out #(
  parameter int VALUE_BITS    = mmbd_pkg::VALUE_BITS_DEF,
  parameter int POSITION_BITS = mmbd_pkg::POSITION_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire mmbd_pkg::pair_ctl_t            ctl,
  input  wire logic signed [VALUE_BITS-1:0]   p0_value,
  input  wire logic [mmbd_pkg::TAG_BITS-1:0]  p0_tag,
  input  wire logic [POSITION_BITS-1:0]       p0_index,
  input  wire logic signed [VALUE_BITS-1:0]   p1_value,
  input  wire logic [mmbd_pkg::TAG_BITS-1:0]  p1_tag,
  input  wire logic [POSITION_BITS-1:0]       p1_index,
  output logic                                pair_ready,
  output logic                                valid,
  input  wire logic                           ready,
  output logic signed [VALUE_BITS-1:0]        point_value,
  output logic [mmbd_pkg::TAG_BITS-1:0]       point_tag,
  output logic [POSITION_BITS-1:0]            point_index,
  output logic                                run_last,
  output logic                                frame_end
);

  logic [1:0]                    cnt;
  logic signed [VALUE_BITS-1:0]  s1_value;
  logic [mmbd_pkg::TAG_BITS-1:0] s1_tag;
  logic [POSITION_BITS-1:0]      s1_index;
  logic                          s1_fend;
  logic                          out_fire;

  assign valid      = cnt != 2'd0;
  assign out_fire   = valid && ready;
  assign pair_ready = (cnt == 2'd0) || ((cnt == 2'd1) && ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (ctl.load) begin
      cnt <= ctl.two ? 2'd2 : 2'd1;
    end else if (out_fire) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      point_value <= p0_value;
      point_tag   <= p0_tag;
      point_index <= p0_index;
      run_last    <= !ctl.two;
      frame_end   <= ctl.fend && !ctl.two;
      s1_value    <= p1_value;
      s1_tag      <= p1_tag;
      s1_index    <= p1_index;
      s1_fend     <= ctl.fend;
    end else if (out_fire) begin
      point_value <= s1_value;
      point_tag   <= s1_tag;
      point_index <= s1_index;
      run_last    <= 1'b1;
      frame_end   <= s1_fend;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/minmax_bucket_downsampler.sv
// top level of the min/max bucket downsampler
//
// samples come in on the sink channel as value and tag; points leave on the
// source channel with value, tag, position in frame, run_last and frame_end.
// the configuration port writes sample_count (index 0) and the number of
// buckets (index 1); write only while no sample is in flight.
// a sample is taken every cycle while the result register has room. it is
// held in the input register, and the points it yields are then registered
// in the result register. throughput is one sample per cycle while the
// output is not stalled; a bucket that closes with two points holds the
// result register until both are sent through the single output port.
// when the receiver stalls, the result register holds its points and the
// input register fills, after which ready drops until the stall clears.
// reset (synchronous, active high) clears both counts, the frame position,
// the bucket accumulator and all pending points; the block emits nothing
// until both counts are written nonzero.
`default_nettype none
module minmax_bucket_downsampler #(
  parameter int VALUE_BITS    = mmbd_pkg::VALUE_BITS_DEF,
  parameter int POSITION_BITS = mmbd_pkg::POSITION_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [mmbd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [mmbd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  mmbd_sample_if.sink                                samples,
  mmbd_point_if.source                               points
);

  logic [mmbd_pkg::COUNT_BITS-1:0]  sample_count;
  logic [mmbd_pkg::BUCKET_BITS-1:0] num_buckets;

  mmbd_pkg::pair_ctl_t              ctl;
  logic                             pair_ready;
  logic signed [VALUE_BITS-1:0]     p0_value, p1_value;
  logic [mmbd_pkg::TAG_BITS-1:0]    p0_tag, p1_tag;
  logic [POSITION_BITS-1:0]         p0_index, p1_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      num_buckets  <= '0;
    end else if (cfg_write) begin
      unique case (mmbd_pkg::cfg_reg_t'(cfg_index))
        mmbd_pkg::REG_SAMPLE_COUNT: begin
          sample_count <= cfg_data[mmbd_pkg::COUNT_BITS-1:0];
        end
        mmbd_pkg::REG_BUCKET_COUNT: begin
          num_buckets <= cfg_data[mmbd_pkg::BUCKET_BITS-1:0];
        end
      endcase
    end
  end

  mmbd_core #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .in_value     (samples.sample_value),
    .in_tag       (samples.sample_tag),
    .sample_count (sample_count),
    .num_buckets  (num_buckets),
    .pair_ready   (pair_ready),
    .ctl          (ctl),
    .p0_value     (p0_value),
    .p0_tag       (p0_tag),
    .p0_index     (p0_index),
    .p1_value     (p1_value),
    .p1_tag       (p1_tag),
    .p1_index     (p1_index)
  );

  mmbd_out #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_out (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .p0_value    (p0_value),
    .p0_tag      (p0_tag),
    .p0_index    (p0_index),
    .p1_value    (p1_value),
    .p1_tag      (p1_tag),
    .p1_index    (p1_index),
    .pair_ready  (pair_ready),
    .valid       (points.valid),
    .ready       (points.ready),
    .point_value (points.point_value),
    .point_tag   (points.point_tag),
    .point_index (points.point_index),
    .run_last    (points.run_last),
    .frame_end   (points.frame_end)
  );

endmodule
`default_nettype wire
